FILE: rtl/fsp_pkg.sv
`default_nettype none

package fsp_pkg;

	localparam int unsigned NumMax = 65535;

	localparam logic [3:0] CONV_C       = 4'd0;
	localparam logic [3:0] CONV_S       = 4'd1;
	localparam logic [3:0] CONV_P       = 4'd2;
	localparam logic [3:0] CONV_D       = 4'd3;
	localparam logic [3:0] CONV_I       = 4'd4;
	localparam logic [3:0] CONV_U       = 4'd5;
	localparam logic [3:0] CONV_X_LOWER = 4'd6;
	localparam logic [3:0] CONV_X_UPPER = 4'd7;
	localparam logic [3:0] CONV_PERCENT = 4'd8;

	localparam logic [7:0] CH_DOT = 8'h2e;

	typedef struct packed {
		logic       hit;
		logic [3:0] code;
	} conv_t;

	function automatic conv_t conv_lookup(input logic [7:0] c);
		conv_t r;
		r.hit  = 1'b1;
		r.code = CONV_PERCENT;
		case (c)
			8'h63: r.code = CONV_C;
			8'h73: r.code = CONV_S;
			8'h70: r.code = CONV_P;
			8'h64: r.code = CONV_D;
			8'h69: r.code = CONV_I;
			8'h75: r.code = CONV_U;
			8'h78: r.code = CONV_X_LOWER;
			8'h58: r.code = CONV_X_UPPER;
			8'h25: r.code = CONV_PERCENT;
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

	// one-hot: bit0 '#', bit1 '0', bit2 '-', bit3 ' ', bit4 '+'
	function automatic logic [4:0] flag_lookup(input logic [7:0] c);
		logic [4:0] r;
		case (c)
			8'h23: r = 5'b00001;
			8'h30: r = 5'b00010;
			8'h2d: r = 5'b00100;
			8'h20: r = 5'b01000;
			8'h2b: r = 5'b10000;
			default: r = 5'b00000;
		endcase
		return r;
	endfunction

	// acc * 10 + digit, saturating
	function automatic logic [15:0] accum(input logic [15:0] acc, input logic [3:0] dig);
		logic [19:0] v;
		v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'd0, dig};
		return (v > 20'(NumMax)) ? 16'(NumMax) : v[15:0];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/format_spec_parser.sv
// An accepted input word is held in the input register; a result word is then registered in the output register.
// Throughput: one input word per cycle while the output register is empty or being taken.
// The input register advances whenever the output register is empty or being taken.
// Reset (arst_n low, asynchronous) empties both registers and returns the parser to idle.
`default_nettype none

module format_spec_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  ch,
	input  wire logic        start_req,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       conversion,
	output logic             ok,
	output logic             alt_form,
	output logic             zero_pad,
	output logic             left_justify,
	output logic             space_sign,
	output logic             plus_sign,
	output logic [15:0]      field_width,
	output logic             has_precision,
	output logic [15:0]      precision_value,
	output logic [7:0]       spec_length
);

	typedef enum logic [1:0] {M_IDLE, M_FLAGS, M_WIDTH, M_PREC} mode_t;

	logic        valid_s1;
	logic [7:0]  ch_s1;
	logic        start_s1;

	mode_t       mode_q;
	logic [4:0]  flags_q;
	logic [15:0] width_q;
	logic        prec_seen_q;
	logic [15:0] prec_q;
	logic [7:0]  count_q;

	logic        out_valid_q;
	logic [3:0]  conv_q;
	logic        ok_q;
	logic [4:0]  oflags_q;
	logic [15:0] owidth_q;
	logic        oprec_seen_q;
	logic [15:0] oprec_q;
	logic [7:0]  olen_q;

	logic        adv;
	logic        fire;

	mode_t       mode_e, mode_n;
	logic [4:0]  flags_e, flags_n;
	logic [15:0] width_e, width_n;
	logic        prec_seen_e, prec_seen_n;
	logic [15:0] prec_e, prec_n;
	logic [7:0]  count_n;
	logic        res_v;
	logic        res_ok;
	logic [3:0]  res_conv;

	fsp_pkg::conv_t cv;
	logic [4:0]  fl;
	logic        is_digit;
	logic        is_nz_digit;
	logic [3:0]  dig;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv;
	assign fire     = valid_s1 && adv;

	always_comb begin
		mode_e      = start_s1 ? M_FLAGS : mode_q;
		flags_e     = start_s1 ? 5'd0 : flags_q;
		width_e     = start_s1 ? 16'd0 : width_q;
		prec_seen_e = start_s1 ? 1'b0 : prec_seen_q;
		prec_e      = start_s1 ? 16'd0 : prec_q;
		count_n     = start_s1 ? 8'd1 : ((count_q == 8'hff) ? count_q : count_q + 8'd1);

		cv          = fsp_pkg::conv_lookup(ch_s1);
		fl          = fsp_pkg::flag_lookup(ch_s1);
		is_digit    = (ch_s1 >= 8'h30) && (ch_s1 <= 8'h39);
		is_nz_digit = is_digit && (ch_s1 != 8'h30);
		dig         = 4'(ch_s1 - 8'h30);

		mode_n      = mode_e;
		flags_n     = flags_e;
		width_n     = width_e;
		prec_seen_n = prec_seen_e;
		prec_n      = prec_e;
		res_v       = 1'b0;
		res_ok      = 1'b0;
		res_conv    = fsp_pkg::CONV_PERCENT;

		if (mode_e != M_IDLE) begin
			if (cv.hit) begin
				res_v    = 1'b1;
				res_ok   = 1'b1;
				res_conv = cv.code;
				mode_n   = M_IDLE;
			end else begin
				case (mode_e)
					M_FLAGS: begin
						if (fl != 5'd0) begin
							flags_n = flags_e | fl;
						end else if (is_nz_digit) begin
							width_n = fsp_pkg::accum(16'd0, dig);
							mode_n  = M_WIDTH;
						end else if (ch_s1 == fsp_pkg::CH_DOT) begin
							prec_seen_n = 1'b1;
							prec_n      = 16'd0;
							mode_n      = M_PREC;
						end else begin
							res_v  = 1'b1;
							mode_n = M_IDLE;
						end
					end
					M_WIDTH: begin
						if (is_digit) begin
							width_n = fsp_pkg::accum(width_e, dig);
						end else if (ch_s1 == fsp_pkg::CH_DOT) begin
							prec_seen_n = 1'b1;
							prec_n      = 16'd0;
							mode_n      = M_PREC;
						end else begin
							res_v  = 1'b1;
							mode_n = M_IDLE;
						end
					end
					M_PREC: begin
						if (is_digit) begin
							prec_n = fsp_pkg::accum(prec_e, dig);
						end else begin
							res_v  = 1'b1;
							mode_n = M_IDLE;
						end
					end
					default: begin
						mode_n = M_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			mode_q      <= M_IDLE;
			flags_q     <= 5'd0;
			width_q     <= 16'd0;
			prec_seen_q <= 1'b0;
			prec_q      <= 16'd0;
			count_q     <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (fire) begin
				if (start_s1 || mode_q != M_IDLE) begin
					count_q <= count_n;
				end
				mode_q      <= mode_n;
				flags_q     <= flags_n;
				width_q     <= width_n;
				prec_seen_q <= prec_seen_n;
				prec_q      <= prec_n;
			end
			if (adv) begin
				out_valid_q <= fire && res_v;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ch_s1    <= ch;
			start_s1 <= start_req;
		end
		if (fire && res_v) begin
			conv_q       <= res_conv;
			ok_q         <= res_ok;
			oflags_q     <= flags_n;
			owidth_q     <= width_n;
			oprec_seen_q <= prec_seen_n;
			oprec_q      <= prec_n;
			olen_q       <= res_ok ? count_n : 8'd0;
		end
	end

	assign out_valid       = out_valid_q;
	assign conversion      = conv_q;
	assign ok              = ok_q;
	assign alt_form        = oflags_q[0];
	assign zero_pad        = oflags_q[1];
	assign left_justify    = oflags_q[2];
	assign space_sign      = oflags_q[3];
	assign plus_sign       = oflags_q[4];
	assign field_width     = owidth_q;
	assign has_precision   = oprec_seen_q;
	assign precision_value = oprec_q;
	assign spec_length     = olen_q;

	// an empty output register never blocks the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("in_ready low with empty output register");

	// failures carry percent and zero length
	a_fail_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> conversion == fsp_pkg::CONV_PERCENT && spec_length == 8'd0)
		else $error("failure word malformed");

	// a parsed spec counts at least its conversion letter
	a_ok_length: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ok |-> spec_length != 8'd0)
		else $error("successful word with zero length");

	// precision digits only after a dot
	a_prec_dot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> has_precision || precision_value == 16'd0)
		else $error("precision value without dot");

	// parser goes idle after each result
	a_idle_after: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res_v |=> mode_q == M_IDLE)
		else $error("parser not idle after result");

endmodule

`default_nettype wire
